// ----- hdl/nearest_free_value_assigner_macros.svh -----
// ----------------------------------------------------------------------------
// Nearest free value assigner assertion macros
// Implication and next-cycle checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef NEAREST_FREE_VALUE_ASSIGNER_MACROS_SVH
`define NEAREST_FREE_VALUE_ASSIGNER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NFVA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfva: implication check failed");

`define NFVA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfva: next-cycle check failed");

`else

`define NFVA_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define NFVA_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/nfva_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest free value assigner package
// Widths, cell command and response types, and bit search helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nfva_pkg;

  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned OFF_BITS   = (VALUE_BITS < 6) ? 2 : 5;
  localparam int unsigned CELL_BITS  = VALUE_BITS - OFF_BITS;
  localparam int unsigned WORD_BITS  = 2 ** OFF_BITS;
  localparam int unsigned CELL_COUNT = 2 ** CELL_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [OFF_BITS-1:0]   off_t;
  typedef logic [CELL_BITS-1:0]  cidx_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  typedef struct packed {
    logic   en;
    value_t val;
  } mark_t;

  typedef struct packed {
    logic  load;
    cidx_t home;
    off_t  off;
    logic  first;
    logic  dn_adv;
    logic  up_adv;
  } cell_cmd_t;

  typedef struct packed {
    logic   req_free;
    logic   lo_hit;
    value_t lo_val;
    logic   hi_hit;
    value_t hi_val;
  } cell_rsp_t;

  function automatic off_t top_set(word_t v);
    off_t r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        r = off_t'(i);
      end
    end
    return r;
  endfunction

  function automatic off_t low_set(word_t v);
    off_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = off_t'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nearest_free_value_assigner.sv -----
// ----------------------------------------------------------------------------
// Nearest free value assigner
// Hands out values from a bounded range, replacing a taken request by the
// nearest free value, lower side first on a tie; value zero is never a
// replacement.
// ----------------------------------------------------------------------------
// Input channel: requested_value_i, taken on in_valid_i with in_stall_o low.
// Output channel: assigned_value_o, was_replaced_o, no_free_value_o under
// out_valid_o; the receiver holds a beat with out_stall_i.
// The bitmap sits in a row of cells, one 2^OFF_BITS-bit word each. A search
// beat starts in the word of the request and moves one cell down and one cell
// up per cycle; each cell picks its nearest free bit in that cycle.
// A free request goes from the search step straight to the finish step; a
// taken one steps word by word, stopping at the range ends or once no
// farther word can win. The next request is taken only in the idle state
// after the result is loaded, so each request finishes before the next.
// A result waiting under out_stall_i does not block the next request; the
// following result holds in the finish step until the output register drains.
// Reset clears the whole bitmap at once and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_free_value_assigner_macros.svh"

module nearest_free_value_assigner (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nfva_pkg::value_t requested_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output nfva_pkg::value_t assigned_value_o,
  output logic             was_replaced_o,
  output logic             no_free_value_o
);
  import nfva_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e    state_q, state_d;
  logic      lo_act_q, lo_act_d, hi_act_q, hi_act_d;
  logic      lo_fnd_q, lo_fnd_d, hi_fnd_q, hi_fnd_d;
  logic      first_q, first_d, direct_q, direct_d;
  logic      out_vld_q, out_vld_d;
  cidx_t     lo_wd_q, lo_wd_d, hi_wd_q, hi_wd_d;
  value_t    req_q, req_d, lo_val_q, lo_val_d, hi_val_q, hi_val_d;
  value_t    out_val_q;
  logic      out_rep_q, out_fail_q;

  logic [CELL_COUNT-1:0] dn_tok, up_tok;
  cell_rsp_t rsp [CELL_COUNT];
  cell_rsp_t rsp_all;
  cell_cmd_t cmd;
  mark_t     mark;

  logic   in_acc, stop_all, lo_go, hi_go, lo_prune, hi_prune;
  logic   lo_fnd_any, hi_fnd_any, pick_lo, found, fin_go;
  value_t lo_any_val, hi_any_val, lo_top_nx, hi_bot_nx, dl, du, sel_val;
  logic   sel_rep, sel_fail;
  cidx_t  lo_wd_m1, hi_wd_p1;

  for (genvar j = 0; j < CELL_COUNT; j++) begin : g_cell
    logic dn_in, up_in;
    if (j == CELL_COUNT - 1) begin : g_dn_end
      assign dn_in = 1'b0;
    end else begin : g_dn
      assign dn_in = dn_tok[j+1];
    end
    if (j == 0) begin : g_up_end
      assign up_in = 1'b0;
    end else begin : g_up
      assign up_in = up_tok[j-1];
    end
    nfva_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (cidx_t'(j)),
      .cmd_i      (cmd),
      .mark_i     (mark),
      .dn_tok_i   (dn_in),
      .up_tok_i   (up_in),
      .dn_tok_o   (dn_tok[j]),
      .up_tok_o   (up_tok[j]),
      .rsp_o      (rsp[j])
    );
  end

  always_comb begin
    rsp_all = '0;
    for (int k = 0; k < CELL_COUNT; k++) begin
      rsp_all = rsp_all | rsp[k];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    stop_all   = first_q & rsp_all.req_free;
    lo_fnd_any = lo_fnd_q | rsp_all.lo_hit;
    hi_fnd_any = hi_fnd_q | rsp_all.hi_hit;
    lo_any_val = rsp_all.lo_hit ? rsp_all.lo_val : lo_val_q;
    hi_any_val = rsp_all.hi_hit ? rsp_all.hi_val : hi_val_q;
    lo_wd_m1   = lo_wd_q - 1'b1;
    hi_wd_p1   = hi_wd_q + 1'b1;
    lo_top_nx  = {lo_wd_m1, off_t'('1)};
    hi_bot_nx  = {hi_wd_p1, off_t'('0)};
    lo_prune   = hi_fnd_any && ((req_q - lo_top_nx) > (hi_any_val - req_q));
    hi_prune   = lo_fnd_any && ((hi_bot_nx - req_q) >= (req_q - lo_any_val));
    lo_go = (state_q == ST_SRCH) && lo_act_q && !stop_all && !rsp_all.lo_hit &&
            (lo_wd_q != '0) && !lo_prune;
    hi_go = (state_q == ST_SRCH) && hi_act_q && !stop_all && !rsp_all.hi_hit &&
            (hi_wd_q != '1) && !hi_prune;

    dl       = req_q - lo_val_q;
    du       = hi_val_q - req_q;
    found    = lo_fnd_q | hi_fnd_q;
    pick_lo  = lo_fnd_q && (!hi_fnd_q || (dl <= du));
    sel_val  = direct_q ? req_q : (pick_lo ? lo_val_q : (hi_fnd_q ? hi_val_q : req_q));
    sel_rep  = !direct_q && found;
    sel_fail = !direct_q && !found;
    fin_go   = (state_q == ST_FIN) && (!out_vld_q || !out_stall_i);

    cmd.load   = in_acc;
    cmd.home   = requested_value_i[VALUE_BITS-1:OFF_BITS];
    cmd.off    = req_q[OFF_BITS-1:0];
    cmd.first  = first_q;
    cmd.dn_adv = lo_go;
    cmd.up_adv = hi_go;

    mark.en  = fin_go && (direct_q || found);
    mark.val = sel_val;
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    lo_act_d = lo_act_q;
    hi_act_d = hi_act_q;
    lo_fnd_d = lo_fnd_q;
    hi_fnd_d = hi_fnd_q;
    lo_val_d = lo_val_q;
    hi_val_d = hi_val_q;
    lo_wd_d  = lo_wd_q;
    hi_wd_d  = hi_wd_q;
    first_d  = first_q;
    direct_d = direct_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d    = requested_value_i;
          lo_wd_d  = requested_value_i[VALUE_BITS-1:OFF_BITS];
          hi_wd_d  = requested_value_i[VALUE_BITS-1:OFF_BITS];
          lo_act_d = 1'b1;
          hi_act_d = 1'b1;
          lo_fnd_d = 1'b0;
          hi_fnd_d = 1'b0;
          first_d  = 1'b1;
          direct_d = 1'b0;
          state_d  = ST_SRCH;
        end
      end
      ST_SRCH: begin
        first_d = 1'b0;
        if (stop_all) begin
          direct_d = 1'b1;
        end
        if (rsp_all.lo_hit) begin
          lo_fnd_d = 1'b1;
          lo_val_d = rsp_all.lo_val;
        end
        if (rsp_all.hi_hit) begin
          hi_fnd_d = 1'b1;
          hi_val_d = rsp_all.hi_val;
        end
        lo_act_d = lo_go;
        hi_act_d = hi_go;
        if (lo_go) begin
          lo_wd_d = lo_wd_m1;
        end
        if (hi_go) begin
          hi_wd_d = hi_wd_p1;
        end
        if (!lo_go && !hi_go) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fin_go) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lo_act_q  <= 1'b0;
      hi_act_q  <= 1'b0;
      lo_fnd_q  <= 1'b0;
      hi_fnd_q  <= 1'b0;
      first_q   <= 1'b0;
      direct_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lo_act_q  <= lo_act_d;
      hi_act_q  <= hi_act_d;
      lo_fnd_q  <= lo_fnd_d;
      hi_fnd_q  <= hi_fnd_d;
      first_q   <= first_d;
      direct_q  <= direct_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lo_val_q <= lo_val_d;
    hi_val_q <= hi_val_d;
    lo_wd_q  <= lo_wd_d;
    hi_wd_q  <= hi_wd_d;
    if (fin_go) begin
      out_val_q  <= sel_val;
      out_rep_q  <= sel_rep;
      out_fail_q <= sel_fail;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign assigned_value_o = out_val_q;
  assign was_replaced_o   = out_rep_q;
  assign no_free_value_o  = out_fail_q;

  `NFVA_ASSERT_IMP(a_dn_tok_single, clk_i, rst_ni, 1'b1, $onehot0(dn_tok))
  `NFVA_ASSERT_IMP(a_up_tok_single, clk_i, rst_ni, 1'b1, $onehot0(up_tok))
  `NFVA_ASSERT_IMP(a_dn_tok_idle, clk_i, rst_ni, !lo_act_q, dn_tok == '0)
  `NFVA_ASSERT_NXT(a_accept_search, clk_i, rst_ni, in_acc, (state_q == ST_SRCH) && first_q)
  `NFVA_ASSERT_IMP(a_replace_moves, clk_i, rst_ni, mark.en && sel_rep, sel_val != req_q)

endmodule

`default_nettype wire

// ----- hdl/nfva_cell.sv -----
// ----------------------------------------------------------------------------
// Nearest free value assigner cell
// Holds one word of the occupancy bitmap and passes the downward and upward
// search beats to its neighbors; reports the nearest free bit it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module nfva_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfva_pkg::cidx_t     cell_idx_i,
  input  nfva_pkg::cell_cmd_t cmd_i,
  input  nfva_pkg::mark_t     mark_i,
  input  logic                dn_tok_i,
  input  logic                up_tok_i,
  output logic                dn_tok_o,
  output logic                up_tok_o,
  output nfva_pkg::cell_rsp_t rsp_o
);
  import nfva_pkg::*;

  word_t word_q, word_d;
  logic  dn_q, dn_d, up_q, up_d;
  logic  here;
  word_t ones, free, lo_mask, hi_mask, lo_cand, hi_cand;

  always_comb begin
    ones = '1;
    here = cmd_i.load && (cmd_i.home == cell_idx_i);
    dn_d = cmd_i.load ? here : (cmd_i.dn_adv & dn_tok_i);
    up_d = cmd_i.load ? here : (cmd_i.up_adv & up_tok_i);

    word_d = word_q;
    if (mark_i.en && (mark_i.val[VALUE_BITS-1:OFF_BITS] == cell_idx_i)) begin
      word_d[mark_i.val[OFF_BITS-1:0]] = 1'b1;
    end

    free    = ~word_q;
    lo_mask = cmd_i.first ? ~(ones << cmd_i.off) : ones;
    if (cell_idx_i == '0) begin
      lo_mask[0] = 1'b0;
    end
    hi_mask = cmd_i.first ? ((ones << cmd_i.off) << 1) : ones;
    lo_cand = free & lo_mask;
    hi_cand = free & hi_mask;

    rsp_o.req_free = dn_q & cmd_i.first & free[cmd_i.off];
    rsp_o.lo_hit   = dn_q & (|lo_cand);
    rsp_o.lo_val   = dn_q ? {cell_idx_i, top_set(lo_cand)} : '0;
    rsp_o.hi_hit   = up_q & (|hi_cand);
    rsp_o.hi_val   = up_q ? {cell_idx_i, low_set(hi_cand)} : '0;
  end

  assign dn_tok_o = dn_q;
  assign up_tok_o = up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      dn_q   <= 1'b0;
      up_q   <= 1'b0;
    end else begin
      word_q <= word_d;
      dn_q   <= dn_d;
      up_q   <= up_d;
    end
  end

endmodule

`default_nettype wire
